[hdl/igs_pkg.sv]
// ----------------------------------------------------------------------------
// igs_pkg
// Shared constants, widths and types of the importance-gated vector store.
// ----------------------------------------------------------------------------
`default_nettype none

package igs_pkg;

  // Store geometry.
  parameter int CAPACITY = 8;
  parameter int DIM      = 16;
  parameter int TOPK_MAX = 4;

  // Field widths.
  parameter int VAL_W = 16;
  parameter int IMP_W = 16;
  parameter int THR_W = 16;
  parameter int LIM_W = 4;
  parameter int RC_W  = 3;

  // Derived widths.
  parameter int POS_W  = (CAPACITY > 0) ? $clog2(CAPACITY + 1) : 1;
  parameter int CNT_W  = $clog2(CAPACITY + 2);
  parameter int EW     = (DIM > 1) ? $clog2(DIM) : 1;
  parameter int ECW    = $clog2(DIM + 1);
  parameter int K_W    = $clog2(TOPK_MAX + 1);
  parameter int SQ_W   = 31 + $clog2(DIM);
  parameter int DOT_W  = SQ_W + 1;
  parameter int RT_W   = (SQ_W + 1) / 2;
  parameter int PR_W   = 2 * RT_W;
  parameter int DV_W   = DOT_W + 16;
  parameter int SIM_W  = DV_W + 1;
  parameter int RAM_D  = (CAPACITY + 1) * DIM;
  parameter int RAM_AW = $clog2(RAM_D);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_LIMIT     = 2'd1,
    CFG_RESULTS   = 2'd2
  } cfg_idx_t;

  // Configuration held at the top level.
  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic [LIM_W-1:0] lim;
    logic [RC_W-1:0]  rcnt;
  } cfg_t;

  // Command handed from the front part to the back part.
  typedef struct packed {
    logic             valid;
    logic             query;
    logic [IMP_W-1:0] imp;
  } cmd_t;

endpackage

`default_nettype wire

[hdl/igs_ram.sv]
// ----------------------------------------------------------------------------
// igs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module igs_ram #(
  parameter int W = 16,
  parameter int D = 16
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                    wdata,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic      [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/igs_isqrt.sv]
// ----------------------------------------------------------------------------
// igs_isqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module igs_isqrt
  import igs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [SQ_W-1:0] x,
  output logic                 done,
  output logic      [RT_W-1:0] root
);

  localparam int SE_W = 2 * RT_W;
  localparam int CW   = $clog2(RT_W + 1);

  logic [SE_W-1:0]   x_r;
  logic [RT_W+1:0]   rem_r;
  logic [RT_W-1:0]   root_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [RT_W+3:0]   remn;
  logic [RT_W+3:0]   trial;

  // One digit step: bring down two radicand bits and try the next root bit.
  always_comb begin
    remn  = {rem_r, x_r[SE_W-1 -: 2]};
    trial = (RT_W + 4)'({root_r, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= SE_W'(x);
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CW'(RT_W);
      end else if (cnt_r != '0) begin
        x_r <= x_r << 2;
        if (remn >= trial) begin
          rem_r  <= (RT_W + 2)'(remn - trial);
          root_r <= {root_r[RT_W-2:0], 1'b1};
        end else begin
          rem_r  <= (RT_W + 2)'(remn);
          root_r <= {root_r[RT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

[hdl/igs_div.sv]
// ----------------------------------------------------------------------------
// igs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module igs_div
  import igs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [DV_W-1:0] dividend,
  input  wire logic [PR_W-1:0] divisor,
  output logic                 done,
  output logic      [DV_W-1:0] quotient
);

  localparam int CW = $clog2(DV_W + 1);

  logic [DV_W-1:0] q_r;
  logic [PR_W:0]   rem_r;
  logic [PR_W-1:0] d_r;
  logic [CW-1:0]   cnt_r;
  logic            done_r;
  logic [PR_W:0]   remn;

  // Shift the next dividend bit into the partial remainder.
  assign remn = {rem_r[PR_W-1:0], q_r[DV_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= dividend;
        d_r   <= divisor;
        rem_r <= '0;
        cnt_r <= CW'(DV_W);
      end else if (cnt_r != '0) begin
        if (remn >= {1'b0, d_r}) begin
          rem_r <= remn - {1'b0, d_r};
          q_r   <= {q_r[DV_W-2:0], 1'b1};
        end else begin
          rem_r <= remn;
          q_r   <= {q_r[DV_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

[hdl/igs_front.sv]
// ----------------------------------------------------------------------------
// igs_front
// Collects vector elements into the staging buffer and hands a finished
// vector to the back part as a store or query command.
// ----------------------------------------------------------------------------
`default_nettype none

module igs_front
  import igs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_mode,
  input  wire logic [VAL_W-1:0]  in_elem_value,
  input  wire logic [IMP_W-1:0]  in_importance,
  input  wire logic              in_last,
  output cmd_t                   cmd,
  input  wire logic              cmd_take,
  input  wire logic              stg_free,
  input  wire logic [EW-1:0]     stg_addr,
  output logic      [VAL_W-1:0]  stg_data
);

  logic [VAL_W-1:0] stg_r [DIM];
  logic [ECW-1:0]   cnt_r;
  logic             busy_r;
  cmd_t             cmd_r;
  logic             acc;

  assign acc      = in_valid && !in_stall;
  assign in_stall = busy_r;

  // Staging buffer: write the arriving element, zero the tail on the last one.
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < DIM; i++) begin
        if (ECW'(i) == cnt_r) begin
          stg_r[i] <= in_elem_value;
        end else if (in_last && (ECW'(i) > cnt_r)) begin
          stg_r[i] <= '0;
        end
      end
    end
  end

  // Element counter, command slot and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      cmd_r.valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        cmd_r.valid <= 1'b0;
      end
      if (stg_free) begin
        busy_r <= 1'b0;
      end
      if (acc) begin
        if (in_last) begin
          cnt_r       <= '0;
          busy_r      <= 1'b1;
          cmd_r.valid <= 1'b1;
          cmd_r.query <= in_mode;
          cmd_r.imp   <= in_importance;
        end else if (cnt_r < ECW'(DIM)) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign cmd      = cmd_r;
  assign stg_data = stg_r[stg_addr];

endmodule

`default_nettype wire

[hdl/igs_back.sv]
// ----------------------------------------------------------------------------
// igs_back
// Carries out store and query commands: entry memory, eviction, similarity
// scoring and ranked emission of the best entries.
// ----------------------------------------------------------------------------
`default_nettype none

module igs_back
  import igs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cfg_t                   cfg,
  input  cmd_t                   cmd,
  output logic                   cmd_take,
  output logic                   stg_free,
  output logic      [EW-1:0]     stg_addr,
  input  wire logic [VAL_W-1:0]  stg_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [1:0]        out_rank,
  output logic      [3:0]        out_elem_index,
  output logic      [VAL_W-1:0]  out_value,
  output logic                   out_last_of_run
);

  typedef enum logic [4:0] {
    S_IDLE, S_STW, S_EVCHK, S_MIN, S_SHIFT, S_QN, S_QSQ, S_DOT, S_ESQ,
    S_MUL, S_DVS, S_DIV, S_SEL, S_SCAN, S_EMR, S_EML, S_EMW, S_DONE
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         count_r;
  logic [POS_W-1:0]         ptr_r [CAPACITY+1];
  logic [IMP_W-1:0]         imp_r [CAPACITY+1];
  logic signed [SIM_W-1:0]  sim_r [CAPACITY+1];
  logic [CAPACITY:0]        used_r;
  logic [ECW-1:0]           idx_r;
  logic [EW-1:0]            idx_d_r;
  logic                     rd_v_r;
  logic [CNT_W-1:0]         ent_r;
  logic [POS_W-1:0]         slot_r;
  logic [POS_W-1:0]         min_r;
  logic [IMP_W-1:0]         minimp_r;
  logic [SQ_W-1:0]          acc_q_r;
  logic [SQ_W-1:0]          acc_e_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [RT_W-1:0]          nq_r;
  logic [RT_W-1:0]          ne_r;
  logic [PR_W-1:0]          prod_r;
  logic [K_W-1:0]           rank_r;
  logic [K_W-1:0]           k_r;
  logic [POS_W-1:0]         best_r;
  logic signed [SIM_W-1:0]  bsim_r;
  logic                     have_r;
  logic                     out_valid_r;
  logic [1:0]               out_rank_r;
  logic [3:0]               out_idx_r;
  logic [VAL_W-1:0]         out_val_r;
  logic                     out_last_r;

  logic [CNT_W-1:0]         lim;
  logic [K_W-1:0]           k_now;
  logic [POS_W-1:0]         rd_slot;
  logic [RAM_AW-1:0]        raddr;
  logic [RAM_AW-1:0]        waddr;
  logic [VAL_W-1:0]         rdata;
  logic                     we;
  logic signed [VAL_W-1:0]  qv;
  logic signed [VAL_W-1:0]  ev;
  logic signed [31:0]       qq;
  logic signed [31:0]       ee;
  logic signed [31:0]       qe;
  logic                     sq_start;
  logic [SQ_W-1:0]          sq_x;
  logic                     sq_done;
  logic [RT_W-1:0]          sq_root;
  logic                     dv_start;
  logic [DOT_W-1:0]         dot_mag;
  logic                     dv_done;
  logic [DV_W-1:0]          dv_q;
  logic signed [SIM_W-1:0]  sim_new;

  // Effective limits after clamping to the store geometry.
  always_comb begin
    if (32'(cfg.lim) > CAPACITY) begin
      lim = CNT_W'(CAPACITY);
    end else begin
      lim = CNT_W'(cfg.lim);
    end
    if ((32'(cfg.rcnt) <= TOPK_MAX) && (32'(cfg.rcnt) <= 32'(count_r))) begin
      k_now = K_W'(cfg.rcnt);
    end else if (TOPK_MAX <= 32'(count_r)) begin
      k_now = K_W'(TOPK_MAX);
    end else begin
      k_now = K_W'(count_r);
    end
  end

  // Memory addressing and staging read address.
  assign rd_slot  = (state_r == S_DOT) ? ptr_r[POS_W'(ent_r)] : ptr_r[best_r];
  assign raddr    = RAM_AW'(rd_slot) * RAM_AW'(DIM) + RAM_AW'(idx_r);
  assign waddr    = RAM_AW'(slot_r) * RAM_AW'(DIM) + RAM_AW'(idx_r);
  assign we       = (state_r == S_STW);
  assign stg_addr = (state_r == S_DOT) ? idx_d_r : idx_r[EW-1:0];

  igs_ram #(.W(VAL_W), .D(RAM_D)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (stg_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Element products for norms and the dot product.
  always_comb begin
    qv = signed'(stg_data);
    ev = signed'(rdata);
    qq = qv * qv;
    ee = ev * ev;
    qe = qv * ev;
  end

  // Square root unit shared by both norms, and the divider unit.
  assign sq_start = ((state_r == S_QN) && (idx_r == ECW'(DIM))) ||
                    ((state_r == S_DOT) && (idx_r == ECW'(DIM)) && !rd_v_r);
  assign sq_x     = (state_r == S_QN) ? acc_q_r : acc_e_r;

  igs_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign dv_start = (state_r == S_DVS) && (prod_r != '0);
  assign dot_mag  = (dot_r < 0) ? DOT_W'(-dot_r) : DOT_W'(dot_r);

  igs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend ({dot_mag, 16'b0}),
    .divisor  (prod_r),
    .done     (dv_done),
    .quotient (dv_q)
  );

  // Quotient takes the sign of the dot product, so it truncates toward zero.
  assign sim_new = (dot_r < 0) ? -signed'({1'b0, dv_q}) : signed'({1'b0, dv_q});

  assign cmd_take = (state_r == S_IDLE) && cmd.valid;
  assign stg_free = (state_r == S_DONE);

  // Command sequencer with registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      for (int i = 0; i <= CAPACITY; i++) begin
        ptr_r[i] <= POS_W'(i);
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (cmd.valid) begin
            if (cmd.query) begin
              acc_q_r <= '0;
              state_r <= S_QN;
            end else if (cmd.imp < cfg.thr) begin
              state_r <= S_DONE;
            end else begin
              slot_r                  <= ptr_r[POS_W'(count_r)];
              imp_r[POS_W'(count_r)]  <= cmd.imp;
              count_r                 <= count_r + 1'b1;
              state_r                 <= S_STW;
            end
          end
        end
        // Copy the staging buffer into the chosen slot.
        S_STW: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == ECW'(DIM - 1)) begin
            state_r <= S_EVCHK;
          end
        end
        S_EVCHK: begin
          if (count_r > lim) begin
            min_r    <= '0;
            minimp_r <= imp_r[0];
            ent_r    <= CNT_W'(1);
            state_r  <= S_MIN;
          end else begin
            state_r <= S_DONE;
          end
        end
        // Find the first entry with the lowest importance.
        S_MIN: begin
          if (ent_r < count_r) begin
            if (imp_r[POS_W'(ent_r)] < minimp_r) begin
              min_r    <= POS_W'(ent_r);
              minimp_r <= imp_r[POS_W'(ent_r)];
            end
            ent_r <= ent_r + 1'b1;
          end else begin
            state_r <= S_SHIFT;
          end
        end
        // Close up the order list; the freed slot moves to the end.
        S_SHIFT: begin
          for (int j = 0; j < CAPACITY; j++) begin
            if ((POS_W'(j) >= min_r) && (CNT_W'(j) < count_r - 1'b1)) begin
              ptr_r[j] <= ptr_r[j+1];
              imp_r[j] <= imp_r[j+1];
            end
          end
          ptr_r[POS_W'(count_r - 1'b1)] <= ptr_r[min_r];
          count_r <= count_r - 1'b1;
          state_r <= S_EVCHK;
        end
        // Query norm accumulation.
        S_QN: begin
          if (idx_r < ECW'(DIM)) begin
            acc_q_r <= acc_q_r + SQ_W'($unsigned(qq));
            idx_r   <= idx_r + 1'b1;
          end else begin
            state_r <= S_QSQ;
          end
        end
        S_QSQ: begin
          if (sq_done) begin
            nq_r    <= sq_root;
            ent_r   <= '0;
            idx_r   <= '0;
            acc_e_r <= '0;
            dot_r   <= '0;
            state_r <= (count_r == '0) ? S_SEL : S_DOT;
          end
        end
        // Stream one entry against the query.
        S_DOT: begin
          rd_v_r  <= (idx_r < ECW'(DIM));
          idx_d_r <= idx_r[EW-1:0];
          if (idx_r < ECW'(DIM)) begin
            idx_r <= idx_r + 1'b1;
          end
          if (rd_v_r) begin
            acc_e_r <= acc_e_r + SQ_W'($unsigned(ee));
            dot_r   <= dot_r + DOT_W'(qe);
          end
          if ((idx_r == ECW'(DIM)) && !rd_v_r) begin
            state_r <= S_ESQ;
          end
        end
        S_ESQ: begin
          if (sq_done) begin
            ne_r    <= sq_root;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PR_W'(nq_r) * PR_W'(ne_r);
          state_r <= S_DVS;
        end
        S_DVS: begin
          if (prod_r == '0) begin
            sim_r[POS_W'(ent_r)] <= '0;
            ent_r   <= ent_r + 1'b1;
            idx_r   <= '0;
            acc_e_r <= '0;
            dot_r   <= '0;
            state_r <= (ent_r + 1'b1 == count_r) ? S_SEL : S_DOT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            sim_r[POS_W'(ent_r)] <= sim_new;
            ent_r   <= ent_r + 1'b1;
            idx_r   <= '0;
            acc_e_r <= '0;
            dot_r   <= '0;
            state_r <= (ent_r + 1'b1 == count_r) ? S_SEL : S_DOT;
          end
        end
        // Ranking setup.
        S_SEL: begin
          k_r     <= k_now;
          rank_r  <= '0;
          used_r  <= '0;
          ent_r   <= '0;
          have_r  <= 1'b0;
          state_r <= (k_now == '0) ? S_DONE : S_SCAN;
        end
        // One pass over the entries picks the best one not yet returned.
        S_SCAN: begin
          if (ent_r < count_r) begin
            if (!used_r[POS_W'(ent_r)] &&
                (!have_r || (sim_r[POS_W'(ent_r)] > bsim_r))) begin
              best_r <= POS_W'(ent_r);
              bsim_r <= sim_r[POS_W'(ent_r)];
              have_r <= 1'b1;
            end
            ent_r <= ent_r + 1'b1;
          end else begin
            used_r[best_r] <= 1'b1;
            idx_r          <= '0;
            state_r        <= S_EMR;
          end
        end
        S_EMR: begin
          state_r <= S_EML;
        end
        S_EML: begin
          out_valid_r <= 1'b1;
          out_rank_r  <= 2'(rank_r);
          out_idx_r   <= 4'(idx_r);
          out_val_r   <= rdata;
          out_last_r  <= (rank_r == k_r - 1'b1) && (idx_r == ECW'(DIM - 1));
          state_r     <= S_EMW;
        end
        // Hold the result until the receiver takes it.
        S_EMW: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (idx_r == ECW'(DIM - 1)) begin
              if (rank_r == k_r - 1'b1) begin
                state_r <= S_DONE;
              end else begin
                rank_r  <= rank_r + 1'b1;
                ent_r   <= '0;
                have_r  <= 1'b0;
                state_r <= S_SCAN;
              end
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_EMR;
            end
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rank        = out_rank_r;
  assign out_elem_index  = out_idx_r;
  assign out_value       = out_val_r;
  assign out_last_of_run = out_last_r;

  // The entry count never passes capacity between commands.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (32'(count_r) <= CAPACITY))
    else $error("entry count above capacity");

  // A result is only presented while the emitter waits for it to be taken.
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMW))
    else $error("result valid outside emission");

  // Taking a command always starts work.
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> (state_r != S_IDLE))
    else $error("command taken but sequencer idle");

endmodule

`default_nettype wire

[hdl/importance_gated_store_topk_cosine.sv]
// ----------------------------------------------------------------------------
// importance_gated_store_topk_cosine
// Importance-gated vector store with top-k cosine similarity retrieval.
// ----------------------------------------------------------------------------
// Vectors arrive one element per request, one request per cycle while the
// input is not stalled. On the last element the block stalls its input until
// the vector has been handled. A store copies the vector into the entry
// memory, then evicts the first entry of lowest importance, one at a time,
// until the count is within the limit. A query accumulates the query norm,
// then per entry streams the elements through the memory read port, the
// shared square-root unit and the bit-serial divider, then ranks once per
// returned entry and emits result elements while the output is not stalled.
// Entry memory is not cleared at reset; only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module importance_gated_store_topk_cosine
  import igs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_mode,
  input  wire logic [15:0]      in_elem_value,
  input  wire logic [15:0]      in_importance,
  input  wire logic             in_last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [1:0]       out_rank,
  output logic      [3:0]       out_elem_index,
  output logic      [15:0]      out_value,
  output logic                  out_last_of_run,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);

  cfg_t             cfg_r;
  cmd_t             cmd;
  logic             cmd_take;
  logic             stg_free;
  logic [EW-1:0]    stg_addr;
  logic [VAL_W-1:0] stg_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr  <= '0;
      cfg_r.lim  <= LIM_W'(8);
      cfg_r.rcnt <= RC_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: cfg_r.thr  <= cfg_data[THR_W-1:0];
        CFG_LIMIT:     cfg_r.lim  <= cfg_data[LIM_W-1:0];
        CFG_RESULTS:   cfg_r.rcnt <= cfg_data[RC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  igs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_elem_value (in_elem_value),
    .in_importance (in_importance),
    .in_last       (in_last),
    .cmd           (cmd),
    .cmd_take      (cmd_take),
    .stg_free      (stg_free),
    .stg_addr      (stg_addr),
    .stg_data      (stg_data)
  );

  igs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .cmd_take        (cmd_take),
    .stg_free        (stg_free),
    .stg_addr        (stg_addr),
    .stg_data        (stg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rank        (out_rank),
    .out_elem_index  (out_elem_index),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
